/* src/psas_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package psas_pkg;

  localparam int ID_W      = 8;
  localparam int REQ_W     = 8;
  localparam int LEVEL_W   = 4;
  localparam int BURST_W   = 16;
  localparam int WAIT_W    = 4;
  localparam int STAMP_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  localparam logic [0:0] OP_ADD      = 1'b0;
  localparam logic [0:0] OP_DISPATCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ADDED      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DISPATCHED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGING   = 1'd1;

  localparam logic [BURST_W-1:0] QUANTUM_RST = 16'd10;
  localparam logic [WAIT_W-1:0]  AGING_RST   = 4'd3;

  typedef struct packed {
    logic [0:0]         operation;
    logic [ID_W-1:0]    task_id;
    logic [REQ_W-1:0]   priority_req;
    logic [BURST_W-1:0] burst;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     chosen_id;
    logic [BURST_W-1:0]  slice;
    logic                finished;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [LEVEL_W-1:0] level;
    logic [BURST_W-1:0] burst;
    logic [WAIT_W-1:0]  wait_cnt;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef enum logic {
    CMP_SELECT,
    CMP_OLDEST
  } cmp_mode_t;

  typedef struct packed {
    logic   better;
    logic   promote;
    entry_t aged;
  } unit_res_t;

endpackage

`default_nettype wire

/* src/psas_table.sv */
`timescale 1ns / 1ps
`default_nettype none

module psas_table #(
  parameter int DEPTH = 16,
  localparam int IdxW = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [IdxW-1:0]   waddr,
  input  wire psas_pkg::entry_t  wdata,
  input  wire logic [IdxW-1:0]   raddr,
  output psas_pkg::entry_t       rdata
);
  import psas_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_r <= mem_q[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* src/psas_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

module psas_unit (
  input  wire psas_pkg::cmp_mode_t           mode,
  input  wire psas_pkg::entry_t              cand,
  input  wire psas_pkg::entry_t              best,
  input  wire logic                          best_found,
  input  wire logic [psas_pkg::STAMP_W-1:0]  order_cnt,
  input  wire logic [psas_pkg::WAIT_W-1:0]   promo_limit,
  output psas_pkg::unit_res_t                res
);
  import psas_pkg::*;

  logic [STAMP_W-1:0] age_cand;
  logic [STAMP_W-1:0] age_best;
  logic               older;
  logic [WAIT_W-1:0]  wait_inc;

  always_comb begin
    age_cand = order_cnt - cand.stamp;
    age_best = order_cnt - best.stamp;
    older    = age_cand > age_best;
    wait_inc = cand.wait_cnt + WAIT_W'(1);

    res.better = 1'b0;
    case (mode)
      CMP_SELECT: begin
        res.better = !best_found || (cand.level < best.level) ||
                     ((cand.level == best.level) &&
                      ((cand.burst < best.burst) ||
                       ((cand.burst == best.burst) && older)));
      end
      CMP_OLDEST: begin
        // higher level first, oldest first within a level
        res.better = !best_found || (cand.level < best.level) ||
                     ((cand.level == best.level) && older);
      end
      default: begin
        res.better = 1'b0;
      end
    endcase

    // one more wait, promotion to the next level up at the limit
    res.promote       = wait_inc >= promo_limit;
    res.aged          = cand;
    res.aged.wait_cnt = wait_inc;
    if (res.promote) begin
      res.aged.level    = cand.level - LEVEL_W'(1);
      res.aged.wait_cnt = '0;
    end
  end

endmodule

`default_nettype wire

/* src/priority_sjf_aging_scheduler.sv */
`timescale 1ns / 1ps
`default_nettype none

// Priority scheduler with shortest-burst choice per level and aging. The task
// table sits in a single-port-read memory that one sequencer scans entry by
// entry through a shared compare and aging unit. An add item searches for the
// lowest free slot. A dispatch item makes one scan to select and, if a task is
// found, one scan to age, plus one scan for every task promoted in that
// dispatch, since promoted tasks are re-queued highest level first and oldest
// first within a level, by one scan each. The block takes no new item until the
// current one has its result in the output register. The user must write the
// quantum and promotion limit via the cfg port only while idle (not enforced).

module priority_sjf_aging_scheduler #(
  parameter int MAX_TASKS    = 16,
  parameter int TOP_LEVEL    = 1,
  parameter int BOTTOM_LEVEL = 10
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire psas_pkg::in_item_t              in_item,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output psas_pkg::out_item_t                  out_item,
  input  wire logic                            cfg_we,
  input  wire logic [psas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [psas_pkg::CFG_W-1:0]      cfg_wdata
);
  import psas_pkg::*;

  localparam int IdxW = $clog2(MAX_TASKS);
  localparam int CntW = $clog2(MAX_TASKS + 1);
  localparam logic [IdxW-1:0]    LastIdx = IdxW'(MAX_TASKS - 1);
  localparam logic [REQ_W-1:0]   ReqTop  = REQ_W'(TOP_LEVEL);
  localparam logic [REQ_W-1:0]   ReqBot  = REQ_W'(BOTTOM_LEVEL);
  localparam logic [LEVEL_W-1:0] TopLvl  = LEVEL_W'(TOP_LEVEL);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE,
    S_SEL,
    S_GRANT,
    S_AGE,
    S_ORD,
    S_STAMP,
    S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [IdxW-1:0]        scan_r, scan_nxt;
  logic                   scan_on_r, scan_on_nxt;
  logic                   pipe_v_r, pipe_v_nxt;
  logic [IdxW-1:0]        pipe_idx_r, pipe_idx_nxt;
  in_item_t               item_r, item_nxt;
  logic                   pick_found_r, pick_found_nxt;
  logic [IdxW-1:0]        pick_idx_r, pick_idx_nxt;
  entry_t                 pick_rec_r, pick_rec_nxt;
  logic [IdxW-1:0]        skip_idx_r, skip_idx_nxt;
  logic [CntW-1:0]        pend_cnt_r, pend_cnt_nxt;
  out_item_t              res_r, res_nxt;
  logic [STAMP_W-1:0]     order_cnt_r, order_cnt_nxt;
  logic [BURST_W-1:0]     quantum_r, quantum_nxt;
  logic [WAIT_W-1:0]      promo_limit_r, promo_limit_nxt;
  logic [MAX_TASKS-1:0]   valid_r, valid_nxt;
  logic [MAX_TASKS-1:0]   pend_r, pend_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_item_r, out_item_nxt;

  logic                   mem_we;
  logic [IdxW-1:0]        mem_waddr;
  entry_t                 mem_wdata;
  entry_t                 mem_rdata;
  cmp_mode_t              cmp_mode;
  unit_res_t              u_res;
  logic                   last_seen;
  logic [REQ_W-1:0]       req_lvl;
  logic [BURST_W-1:0]     grant_slice;
  logic [BURST_W-1:0]     grant_rem;

  psas_table #(
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (scan_r),
    .rdata (mem_rdata)
  );

  assign cmp_mode = (state_r == S_ORD) ? CMP_OLDEST : CMP_SELECT;

  psas_unit u_unit (
    .mode        (cmp_mode),
    .cand        (mem_rdata),
    .best        (pick_rec_r),
    .best_found  (pick_found_r),
    .order_cnt   (order_cnt_r),
    .promo_limit (promo_limit_r),
    .res         (u_res)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    state_nxt       = state_r;
    scan_nxt        = scan_r;
    scan_on_nxt     = scan_on_r;
    pipe_v_nxt      = 1'b0;
    pipe_idx_nxt    = pipe_idx_r;
    item_nxt        = item_r;
    pick_found_nxt  = pick_found_r;
    pick_idx_nxt    = pick_idx_r;
    pick_rec_nxt    = pick_rec_r;
    skip_idx_nxt    = skip_idx_r;
    pend_cnt_nxt    = pend_cnt_r;
    res_nxt         = res_r;
    order_cnt_nxt   = order_cnt_r;
    quantum_nxt     = quantum_r;
    promo_limit_nxt = promo_limit_r;
    valid_nxt       = valid_r;
    pend_nxt        = pend_r;
    out_valid_nxt   = out_valid_r;
    out_item_nxt    = out_item_r;
    mem_we          = 1'b0;
    mem_waddr       = pipe_idx_r;
    mem_wdata       = u_res.aged;

    if (cfg_we) begin
      case (cfg_index)
        CFG_QUANTUM: quantum_nxt = cfg_wdata;
        CFG_AGING:   promo_limit_nxt = cfg_wdata[WAIT_W-1:0];
        default:     ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // table scan: read issued at scan_r, data back in the next cycle
    if (scan_on_r) begin
      pipe_v_nxt   = 1'b1;
      pipe_idx_nxt = scan_r;
      if (scan_r == LastIdx) begin
        scan_on_nxt = 1'b0;
      end else begin
        scan_nxt = scan_r + IdxW'(1);
      end
    end
    last_seen = pipe_v_r && (pipe_idx_r == LastIdx);

    if (item_r.priority_req < ReqTop) begin
      req_lvl = ReqTop;
    end else if (item_r.priority_req > ReqBot) begin
      req_lvl = ReqBot;
    end else begin
      req_lvl = item_r.priority_req;
    end

    grant_slice = (pick_rec_r.burst > quantum_r) ? quantum_r : pick_rec_r.burst;
    grant_rem   = pick_rec_r.burst - grant_slice;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt       = in_item;
          scan_nxt       = '0;
          pick_found_nxt = 1'b0;
          if (in_item.operation == OP_ADD) begin
            state_nxt = S_FREE;
          end else begin
            scan_on_nxt = 1'b1;
            state_nxt   = S_SEL;
          end
        end
      end

      S_FREE: begin
        res_nxt = '0;
        if (!valid_r[scan_r]) begin
          mem_we             = 1'b1;
          mem_waddr          = scan_r;
          mem_wdata.id       = item_r.task_id;
          mem_wdata.level    = req_lvl[LEVEL_W-1:0];
          mem_wdata.burst    = item_r.burst;
          mem_wdata.wait_cnt = '0;
          mem_wdata.stamp    = order_cnt_r;
          valid_nxt[scan_r]  = 1'b1;
          order_cnt_nxt      = order_cnt_r + STAMP_W'(1);
          res_nxt.status     = ST_ADDED;
          state_nxt          = S_DONE;
        end else if (scan_r == LastIdx) begin
          res_nxt.status = ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          scan_nxt = scan_r + IdxW'(1);
        end
      end

      S_SEL: begin
        if (pipe_v_r && valid_r[pipe_idx_r] && u_res.better) begin
          pick_found_nxt = 1'b1;
          pick_idx_nxt   = pipe_idx_r;
          pick_rec_nxt   = mem_rdata;
        end
        if (last_seen) begin
          if (pick_found_nxt) begin
            state_nxt = S_GRANT;
          end else begin
            res_nxt        = '0;
            res_nxt.status = ST_EMPTY;
            state_nxt      = S_DONE;
          end
        end
      end

      S_GRANT: begin
        mem_we             = 1'b1;
        mem_waddr          = pick_idx_r;
        mem_wdata          = pick_rec_r;
        mem_wdata.burst    = grant_rem;
        mem_wdata.wait_cnt = '0;
        mem_wdata.stamp    = order_cnt_r;
        res_nxt.status     = ST_DISPATCHED;
        res_nxt.chosen_id  = pick_rec_r.id;
        res_nxt.slice      = grant_slice;
        res_nxt.finished   = (grant_rem == '0);
        if (grant_rem == '0) begin
          valid_nxt[pick_idx_r] = 1'b0;
        end else begin
          order_cnt_nxt = order_cnt_r + STAMP_W'(1);
        end
        skip_idx_nxt = pick_idx_r;
        pend_cnt_nxt = '0;
        scan_nxt     = '0;
        scan_on_nxt  = 1'b1;
        state_nxt    = S_AGE;
      end

      S_AGE: begin
        if (pipe_v_r && valid_r[pipe_idx_r] && (pipe_idx_r != skip_idx_r) &&
            (mem_rdata.level > TopLvl)) begin
          mem_we = 1'b1;
          if (u_res.promote) begin
            pend_nxt[pipe_idx_r] = 1'b1;
            pend_cnt_nxt         = pend_cnt_r + CntW'(1);
          end
        end
        if (last_seen) begin
          if (pend_cnt_nxt != '0) begin
            pick_found_nxt = 1'b0;
            scan_nxt       = '0;
            scan_on_nxt    = 1'b1;
            state_nxt      = S_ORD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_ORD: begin
        // highest-level, then oldest promoted task goes to its new tail first
        if (pipe_v_r && pend_r[pipe_idx_r] && u_res.better) begin
          pick_found_nxt = 1'b1;
          pick_idx_nxt   = pipe_idx_r;
          pick_rec_nxt   = mem_rdata;
        end
        if (last_seen) begin
          state_nxt = S_STAMP;
        end
      end

      S_STAMP: begin
        mem_we                = 1'b1;
        mem_waddr             = pick_idx_r;
        mem_wdata             = pick_rec_r;
        mem_wdata.stamp       = order_cnt_r;
        order_cnt_nxt         = order_cnt_r + STAMP_W'(1);
        pend_nxt[pick_idx_r]  = 1'b0;
        pend_cnt_nxt          = pend_cnt_r - CntW'(1);
        if (pend_cnt_r == CntW'(1)) begin
          state_nxt = S_DONE;
        end else begin
          pick_found_nxt = 1'b0;
          scan_nxt       = '0;
          scan_on_nxt    = 1'b1;
          state_nxt      = S_ORD;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      scan_on_r     <= 1'b0;
      pipe_v_r      <= 1'b0;
      pick_found_r  <= 1'b0;
      pend_cnt_r    <= '0;
      order_cnt_r   <= '0;
      quantum_r     <= QUANTUM_RST;
      promo_limit_r <= AGING_RST;
      valid_r       <= '0;
      pend_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      scan_on_r     <= scan_on_nxt;
      pipe_v_r      <= pipe_v_nxt;
      pick_found_r  <= pick_found_nxt;
      pend_cnt_r    <= pend_cnt_nxt;
      order_cnt_r   <= order_cnt_nxt;
      quantum_r     <= quantum_nxt;
      promo_limit_r <= promo_limit_nxt;
      valid_r       <= valid_nxt;
      pend_r        <= pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    scan_r     <= scan_nxt;
    pipe_idx_r <= pipe_idx_nxt;
    item_r     <= item_nxt;
    pick_idx_r <= pick_idx_nxt;
    pick_rec_r <= pick_rec_nxt;
    skip_idx_r <= skip_idx_nxt;
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

`default_nettype wire
